>>> rtl/qat_pkg.sv
// shared types and character codes for the quoted argument tokenizer
// no dependencies
package qat_pkg;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChBslash = 8'h5C;

  localparam int unsigned CharW  = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned MaskW  = 8;
  localparam int unsigned DataW  = CharW + CountW + MaskW + CountW;
  localparam int unsigned UserW  = 3;

  typedef struct packed {
    logic              in_dquote;
    logic              in_squote;
    logic              in_group;
    logic              prev_bslash;
    logic [CharW-1:0]  held_char;
    logic              held_valid;
    logic [CountW-1:0] token_count;
    logic [MaskW-1:0]  group_mask;
  } tok_state_t;

  typedef struct packed {
    logic [CharW-1:0]  out_char;
    logic              char_valid;
    logic              token_end;
    logic [CountW-1:0] token_index;
    logic              token_dropped;
    logic              line_end;
    logic [MaskW-1:0]  group_mask;
    logic [CountW-1:0] arg_total;
  } tok_result_t;

  typedef struct packed {
    tok_state_t  state;
    tok_result_t result;
    logic        emit;
  } tok_step_t;

  localparam tok_state_t TokStateReset = '{
    in_dquote:   1'b0,
    in_squote:   1'b0,
    in_group:    1'b0,
    prev_bslash: 1'b0,
    held_char:   '0,
    held_valid:  1'b0,
    token_count: '0,
    group_mask:  '0
  };

endpackage

>>> rtl/quoted_argument_tokenizer_top.sv
// top level of the quoted argument tokenizer: stream ports, state and result register
// depends on qat_pkg and qat_step
// a result is registered and appears in the cycle after the character that causes it is accepted
// throughput: one character per cycle unless a held result stalls; the result register frees in the cycle it is taken
// reset: all tokenizer state and the result register clear asynchronously
// a zero character also returns the state to its reset value after its result
module quoted_argument_tokenizer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [qat_pkg::CharW-1:0]   s_axis_tdata,  // char_code
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_char, token_index, group_mask, arg_total
  output logic [qat_pkg::DataW-1:0]   m_axis_tdata,
  output logic [qat_pkg::UserW-1:0]   m_axis_tuser,  // char_valid, token_end, token_dropped
  output logic                        m_axis_tlast   // line_end
);
  import qat_pkg::*;

  tok_state_t  state_q, state_d;
  tok_result_t res_q;
  logic        out_valid_q, out_valid_d;
  tok_step_t   step;
  logic        in_fire;

  qat_step u_step (
    .state_i (state_q),
    .char_i  (s_axis_tdata),
    .step_o  (step)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign state_d       = in_fire ? step.state : state_q;
  assign out_valid_d   = in_fire ? step.emit : (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TokStateReset;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_fire && step.emit) begin
        res_q <= step.result;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_q.arg_total, res_q.group_mask, res_q.token_index, res_q.out_char};
  assign m_axis_tuser  = {res_q.token_dropped, res_q.token_end, res_q.char_valid};
  assign m_axis_tlast  = res_q.line_end;

endmodule

>>> rtl/qat_step.sv
// next-state and result logic for one input character
// depends on qat_pkg
module qat_step (
  input  qat_pkg::tok_state_t        state_i,
  input  logic [qat_pkg::CharW-1:0]  char_i,
  output qat_pkg::tok_step_t         step_o
);
  import qat_pkg::*;

  logic              outside;
  logic              escaped;
  logic [CountW-1:0] count_inc;
  tok_state_t        st;
  tok_result_t       res;
  logic              emit;

  assign outside   = !state_i.in_dquote && !state_i.in_squote && !state_i.in_group;
  assign escaped   = state_i.prev_bslash;
  assign count_inc = (state_i.token_count != '1) ? state_i.token_count + 1'b1
                                                 : state_i.token_count;

  always_comb begin
    st                = state_i;
    emit              = 1'b0;
    res.out_char      = '0;
    res.char_valid    = 1'b0;
    res.token_end     = 1'b0;
    res.token_index   = state_i.token_count;
    res.token_dropped = 1'b0;
    res.line_end      = 1'b0;
    res.group_mask    = state_i.group_mask;
    res.arg_total     = state_i.token_count;

    if (char_i == ChNul) begin
      emit         = 1'b1;
      res.line_end = 1'b1;
      if (!outside) begin
        res.token_dropped = 1'b1;
      end else if (state_i.held_valid) begin
        res.out_char   = state_i.held_char;
        res.char_valid = 1'b1;
        res.token_end  = 1'b1;
        res.arg_total  = count_inc;
      end
      st = TokStateReset;
    end else begin
      priority if (char_i == ChSpace && outside) begin
        if (state_i.held_valid) begin
          emit           = 1'b1;
          res.out_char   = state_i.held_char;
          res.char_valid = 1'b1;
          res.token_end  = 1'b1;
          res.arg_total  = count_inc;
          st.token_count = count_inc;
          st.held_valid  = 1'b0;
          st.held_char   = '0;
        end
      end else if (char_i == ChDquote && !state_i.in_squote && !state_i.in_group
                   && !escaped) begin
        st.in_dquote = !state_i.in_dquote;
      end else if (char_i == ChSquote && !state_i.in_dquote && !state_i.in_group
                   && !escaped) begin
        st.in_squote = !state_i.in_squote;
      end else if (char_i == ChLparen && !state_i.in_dquote && !state_i.in_squote) begin
        st.in_group = 1'b1;
      end else if (char_i == ChRparen && !state_i.in_dquote && !state_i.in_squote) begin
        st.in_group = 1'b0;
        if (state_i.token_count < CountW'(MaskW)) begin
          st.group_mask[state_i.token_count[$clog2(MaskW)-1:0]] = 1'b1;
        end
      end else if ((char_i == ChDquote || char_i == ChSquote) && escaped
                   && state_i.held_valid) begin
        st.held_char = char_i;
      end else begin
        if (state_i.held_valid) begin
          emit           = 1'b1;
          res.out_char   = state_i.held_char;
          res.char_valid = 1'b1;
        end
        st.held_char  = char_i;
        st.held_valid = 1'b1;
      end
      st.prev_bslash = (char_i == ChBslash);
    end
  end

  assign step_o.state  = st;
  assign step_o.result = res;
  assign step_o.emit   = emit;

endmodule

>>> rtl/qat_checker.sv
// port-level checks for the quoted argument tokenizer, bound to the top level
// depends on qat_pkg
module qat_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [qat_pkg::DataW-1:0]  m_axis_tdata,
  input logic [qat_pkg::UserW-1:0]  m_axis_tuser,
  input logic                       m_axis_tlast
);

  // free result register always takes a new character
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled transaction changed");

  a_end_has_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("token end without character");

  a_drop_only_at_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast && !m_axis_tuser[0])
    else $error("dropped token outside line end or with character");

  a_char_zero_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'h00)
    else $error("character field set without character");

endmodule

bind quoted_argument_tokenizer_top qat_checker u_qat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> test/tb_quoted_argument_tokenizer_top.sv
// testbench for quoted_argument_tokenizer_top: streams command lines through the block
// and checks every result transaction against an internal tokenizer predictor
// depends on qat_pkg and the rtl of the tokenizer
`timescale 1ns / 1ps

module tb_quoted_argument_tokenizer_top;
  import qat_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [CharW-1:0] s_axis_tdata = '0;  // char_code
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // out_char, token_index, group_mask, arg_total
  logic [DataW-1:0] m_axis_tdata;
  logic [UserW-1:0] m_axis_tuser;       // char_valid, token_end, token_dropped
  logic m_axis_tlast;                   // line_end

  quoted_argument_tokenizer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [7:0] line_chars_q[$];
  tok_result_t expected_tokens_q[$];
  int mismatch_cnt = 0;
  int unsigned cyc_cnt = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  logic hold_off;

  // predictor state
  logic dq_open = 1'b0;
  logic sq_open = 1'b0;
  logic grp_open = 1'b0;
  logic [7:0] last_char = '0;
  logic [7:0] pend_char = '0;
  logic pend_valid = 1'b0;
  logic [CountW-1:0] tok_cnt = '0;
  logic [MaskW-1:0] grp_mask = '0;

  assign hold_off = (cyc_cnt >= 1200) && (cyc_cnt < 1450);

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (cyc_cnt[9] || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic tokenize_char(input logic [7:0] c);
    tok_result_t r;
    logic outside;
    logic escaped;
    logic emit;
    outside = !dq_open && !sq_open && !grp_open;
    escaped = (last_char == ChBslash);
    emit = 1'b0;
    r = '0;
    r.token_index = tok_cnt;
    r.group_mask = grp_mask;
    r.arg_total = tok_cnt;
    if (c == ChNul) begin
      if (!outside) begin
        r.token_dropped = 1'b1;
      end else if (pend_valid) begin
        r.out_char = pend_char;
        r.char_valid = 1'b1;
        r.token_end = 1'b1;
        if (tok_cnt != 8'hFF) tok_cnt++;
      end
      r.line_end = 1'b1;
      r.arg_total = tok_cnt;
      emit = 1'b1;
    end else if (c == ChSpace && outside) begin
      if (pend_valid) begin
        r.out_char = pend_char;
        r.char_valid = 1'b1;
        r.token_end = 1'b1;
        if (tok_cnt != 8'hFF) tok_cnt++;
        r.arg_total = tok_cnt;
        pend_valid = 1'b0;
        pend_char = '0;
        emit = 1'b1;
      end
    end else if (c == ChDquote && !sq_open && !grp_open && !escaped) begin
      dq_open = !dq_open;
    end else if (c == ChSquote && !dq_open && !grp_open && !escaped) begin
      sq_open = !sq_open;
    end else if (c == ChLparen && !dq_open && !sq_open) begin
      grp_open = 1'b1;
    end else if (c == ChRparen && !dq_open && !sq_open) begin
      grp_open = 1'b0;
      if (tok_cnt < 8) grp_mask[tok_cnt[2:0]] = 1'b1;
    end else if ((c == ChDquote || c == ChSquote) && escaped && pend_valid) begin
      pend_char = c;
    end else begin
      if (pend_valid) begin
        r.out_char = pend_char;
        r.char_valid = 1'b1;
        emit = 1'b1;
      end
      pend_char = c;
      pend_valid = 1'b1;
    end
    if (emit) expected_tokens_q.push_back(r);
    if (c == ChNul) begin
      dq_open = 1'b0;
      sq_open = 1'b0;
      grp_open = 1'b0;
      last_char = '0;
      pend_char = '0;
      pend_valid = 1'b0;
      tok_cnt = '0;
      grp_mask = '0;
    end else begin
      last_char = c;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("tokenizer error at %0t: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic check_result();
    tok_result_t want;
    if (expected_tokens_q.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction data 0x%0h", m_axis_tdata));
    end else begin
      want = expected_tokens_q.pop_front();
      check_field("out_char", m_axis_tdata[7:0], want.out_char);
      check_field("token_index", m_axis_tdata[15:8], want.token_index);
      check_field("group_mask", m_axis_tdata[23:16], want.group_mask);
      check_field("arg_total", m_axis_tdata[31:24], want.arg_total);
      check_field("char_valid", m_axis_tuser[0], want.char_valid);
      check_field("token_end", m_axis_tuser[1], want.token_end);
      check_field("token_dropped", m_axis_tuser[2], want.token_dropped);
      check_field("line_end", m_axis_tlast, want.line_end);
    end
  endtask

  // cycle count drives the receiver hold-off and the calm windows
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cyc_cnt <= 0;
    else cyc_cnt <= cyc_cnt + 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      tx_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) tokenize_char(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (line_chars_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= line_chars_q.pop_front();
          tx_gap <= gap_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        m_axis_tready <= 1'b0;
        rx_gap <= rx_gap - 1;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 2) == 0) rx_gap <= gap_len();
      end
    end
  end

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 55) return ChSpace;
    if (r < 63) return ChDquote;
    if (r < 71) return ChSquote;
    if (r < 77) return ChLparen;
    if (r < 83) return ChRparen;
    if (r < 90) return ChBslash;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic push_line(input string s);
    for (int i = 0; i < s.len(); i++) line_chars_q.push_back(s[i]);
    line_chars_q.push_back(ChNul);
  endtask

  initial begin
    int unsigned len;
    int unsigned total;
    logic long_done;
    long_done = 1'b0;
    // directed lines: leading quote, escaped quote, empty line, groups, dropped tokens
    push_line("\"a b\" \\\"");
    push_line("");
    push_line("x(y )  'p");
    line_chars_q.push_back(8'hFF);
    line_chars_q.push_back(8'h80);
    line_chars_q.push_back(8'h01);
    line_chars_q.push_back(ChLparen);
    line_chars_q.push_back(ChNul);
    push_line("q\\'");
    total = line_chars_q.size();
    while (total < 1420) begin
      if (!long_done && total > 500) begin
        // saturating token count and mask bits past token seven
        for (int k = 0; k < 262; k++) begin
          line_chars_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
          if (k < 10) line_chars_q.push_back(ChRparen);
          line_chars_q.push_back(ChSpace);
        end
        line_chars_q.push_back(ChNul);
        long_done = 1'b1;
      end else begin
        len = $urandom_range(0, 24);
        for (int k = 0; k < len; k++) line_chars_q.push_back(pick_char());
        line_chars_q.push_back(ChNul);
      end
      total = line_chars_q.size();
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (line_chars_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_tokens_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("quoted_argument_tokenizer_top: match");
    end else begin
      $display("quoted_argument_tokenizer_top: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("quoted_argument_tokenizer_top: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
rtl/qat_pkg.sv
rtl/qat_step.sv
rtl/quoted_argument_tokenizer_top.sv
rtl/qat_checker.sv
test/tb_quoted_argument_tokenizer_top.sv
